FILE: design/lvw_pkg.sv
package lvw_pkg;

	localparam int FIELD_W = 6;
	localparam int COORD_BITS_DEF = 6;

	typedef logic [FIELD_W-1:0] coord_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
	} lvw_in_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		logic   last_point;
	} lvw_out_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} lvw_state_t;

	// controller -> walk datapath
	typedef struct packed {
		logic load;     // capture a new line request
		logic advance;  // take one Bresenham step
	} lvw_ctl_t;

endpackage

FILE: design/line_voxel_walker_3d_top.sv
// channel | dir | payload              | handshake
// req     | in  | lvw_in_t  start/end  | req_valid / req_stall
// pt      | out | lvw_out_t voxel+last | pt_valid  / pt_stall
//
// A line of L voxels (L = largest axis delta + 1, at most 2^COORD_BITS) is
// loaded, then walked at one voxel per cycle from the step unit while pt_stall is low.
// The step unit (one error update per minor axis plus a coordinate inc/dec)
// is reused every cycle; the block takes no new item until the last voxel left.
// req_stall is high from the load until the end voxel is taken.
// pt_stall freezes the walk; the voxel on pt holds until taken.
// Reset (arst_n low) returns the sequencer to idle; datapath regs are not reset.
module line_voxel_walker_3d_top #(
	parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lvw_pkg::lvw_in_t  req,
	output logic              pt_valid,
	input  logic              pt_stall,
	output lvw_pkg::lvw_out_t pt
);

	lvw_pkg::lvw_ctl_t ctl;
	logic              last;

	// sequencer: idle / walking
	lvw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.last      (last),
		.ctl       (ctl)
	);

	// setup and shared step unit; its registers also serve as the output stage
	lvw_walk #(
		.COORD_BITS (COORD_BITS)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.pt     (pt),
		.last   (last)
	);

endmodule

FILE: design/lvw_ctrl.sv
module lvw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               pt_valid,
	input  logic               pt_stall,
	input  logic               last,
	output lvw_pkg::lvw_ctl_t  ctl
);

	lvw_pkg::lvw_state_t state_q;
	lvw_pkg::lvw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		pt_valid    = 1'b0;
		ctl.load    = 1'b0;
		ctl.advance = 1'b0;
		unique case (state_q)
			lvw_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = lvw_pkg::ST_WALK;
				end
			end
			lvw_pkg::ST_WALK: begin
				pt_valid = 1'b1;
				if (!pt_stall) begin
					if (last) begin
						state_d = lvw_pkg::ST_IDLE;
					end else begin
						ctl.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = lvw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/lvw_walk.sv
module lvw_walk #(
	parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lvw_pkg::lvw_ctl_t  ctl,
	input  lvw_pkg::lvw_in_t   req,
	output lvw_pkg::lvw_out_t  pt,
	output logic               last
);

	localparam int CW = COORD_BITS;
	localparam int EW = COORD_BITS + 3;   // signed error term

	// setup
	logic [CW-1:0] s [3];
	logic [CW-1:0] t [3];
	logic [CW-1:0] mag [3];
	logic [2:0]    up;
	lvw_pkg::axis_t drv;
	logic [2:0]    drv_oh, b_oh, c_oh;
	logic [CW-1:0] ma, mb, mc;
	logic [EW-1:0] e1_init, e2_init;

	// walk state
	logic [CW-1:0] cur_q [3];
	logic [2:0]    up_q;
	logic [2:0]    drv_oh_q, b_oh_q, c_oh_q;
	logic [CW-1:0] rem_q;
	logic [EW-1:0] e1_q, e2_q;
	logic [CW:0]   ma2_q, mb2_q, mc2_q;

	// step unit
	logic          stp_b, stp_c;
	logic [2:0]    move;
	logic [EW-1:0] e1_d, e2_d;
	logic [CW-1:0] drv_cur;

	always_comb begin
		s[0] = req.start_x[CW-1:0];
		s[1] = req.start_y[CW-1:0];
		s[2] = req.start_z[CW-1:0];
		t[0] = req.end_x[CW-1:0];
		t[1] = req.end_y[CW-1:0];
		t[2] = req.end_z[CW-1:0];
		for (int i = 0; i < 3; i++) begin
			up[i]  = t[i] > s[i];
			mag[i] = up[i] ? (t[i] - s[i]) : (s[i] - t[i]);
		end
		// ties favor x, then y
		if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
			drv = lvw_pkg::AXIS_X;
		end else if (mag[1] >= mag[2]) begin
			drv = lvw_pkg::AXIS_Y;
		end else begin
			drv = lvw_pkg::AXIS_Z;
		end
		unique case (drv)
			lvw_pkg::AXIS_X: begin
				drv_oh = 3'b001; b_oh = 3'b010; c_oh = 3'b100;
				ma = mag[0]; mb = mag[1]; mc = mag[2];
			end
			lvw_pkg::AXIS_Y: begin
				drv_oh = 3'b010; b_oh = 3'b001; c_oh = 3'b100;
				ma = mag[1]; mb = mag[0]; mc = mag[2];
			end
			lvw_pkg::AXIS_Z: begin
				drv_oh = 3'b100; b_oh = 3'b001; c_oh = 3'b010;
				ma = mag[2]; mb = mag[0]; mc = mag[1];
			end
			default: begin
				drv_oh = 3'b001; b_oh = 3'b010; c_oh = 3'b100;
				ma = mag[0]; mb = mag[1]; mc = mag[2];
			end
		endcase
		e1_init = {2'b00, mb, 1'b0} - {3'b000, ma};
		e2_init = {2'b00, mc, 1'b0} - {3'b000, ma};
	end

	// one Bresenham step: minor axes move when their error is non-negative
	always_comb begin
		stp_b = !e1_q[EW-1];
		stp_c = !e2_q[EW-1];
		move  = drv_oh_q | (b_oh_q & {3{stp_b}}) | (c_oh_q & {3{stp_c}});
		e1_d  = e1_q + {2'b00, mb2_q} - (stp_b ? {2'b00, ma2_q} : '0);
		e2_d  = e2_q + {2'b00, mc2_q} - (stp_c ? {2'b00, ma2_q} : '0);
		drv_cur = '0;
		for (int i = 0; i < 3; i++) begin
			if (drv_oh_q[i]) begin
				drv_cur = cur_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 3; i++) begin
				cur_q[i] <= s[i];
			end
			up_q     <= up;
			drv_oh_q <= drv_oh;
			b_oh_q   <= b_oh;
			c_oh_q   <= c_oh;
			rem_q    <= ma;
			e1_q     <= e1_init;
			e2_q     <= e2_init;
			ma2_q    <= {ma, 1'b0};
			mb2_q    <= {mb, 1'b0};
			mc2_q    <= {mc, 1'b0};
		end else if (ctl.advance) begin
			for (int i = 0; i < 3; i++) begin
				if (move[i]) begin
					cur_q[i] <= up_q[i] ? (cur_q[i] + 1'b1) : (cur_q[i] - 1'b1);
				end
			end
			rem_q <= rem_q - 1'b1;
			e1_q  <= e1_d;
			e2_q  <= e2_d;
		end
	end

	assign last = (rem_q == '0);

	always_comb begin
		pt.point_x    = lvw_pkg::coord_t'(cur_q[0]);
		pt.point_y    = lvw_pkg::coord_t'(cur_q[1]);
		pt.point_z    = lvw_pkg::coord_t'(cur_q[2]);
		pt.last_point = last;
	end

	// a step is only taken while voxels remain
	a_adv_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |-> !last)
		else $error("step taken past the end voxel");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |=> rem_q == $past(rem_q) - 1'b1)
		else $error("remaining count did not drop by one");

	a_drv_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |=> drv_cur != $past(drv_cur))
		else $error("driving axis did not move on a step");

	a_one_drv: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> $onehot(drv_oh_q) && ((drv_oh_q & (b_oh_q | c_oh_q)) == 3'b000))
		else $error("axis roles overlap");

endmodule

FILE: verif/tb_line_voxel_walker_3d_top.sv
module tb_line_voxel_walker_3d_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lvw_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int MAX_VOXELS = 1 << COORD_BITS;
	localparam int COORD_MAX = MAX_VOXELS - 1;
	// cycles with no handshake on either side before the run is called hung
	localparam int HANG_LIMIT = 2000;
	// a full-length line plus its load, with margin
	localparam int TAIL_CYCLES = MAX_VOXELS + 16;
	localparam int MAX_PRINTS = 20;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	lvw_in_t  req;
	logic     pt_valid;
	logic     pt_stall;
	lvw_out_t pt;

	// voxels still owed by the block, oldest first
	lvw_out_t pending_voxels[$];
	lvw_out_t want_voxel;
	int       error_count = 0;
	int       hang_cycles = 0;
	int       stall_left = 0;
	// idling on both channels; cleared for the final stretch
	bit       idle_en = 1'b1;

	line_voxel_walker_3d_top #(
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.pt       (pt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bresenham walk: the axis with the largest delta drives, ties to x then y.
	// Each minor axis steps when its error term is non-negative before the step.
	function automatic void predict_line(input lvw_in_t item);
		int       pos[3];
		int       goal[3];
		int       mag[3];
		int       dir[3];
		int       diff;
		int       lead_i;
		int       m1;
		int       m2;
		int       err1;
		int       err2;
		int       count;
		int       mask;
		axis_t    lead;
		lvw_out_t voxel;
		mask = MAX_VOXELS - 1;
		pos[0] = int'(item.start_x) & mask;
		pos[1] = int'(item.start_y) & mask;
		pos[2] = int'(item.start_z) & mask;
		goal[0] = int'(item.end_x) & mask;
		goal[1] = int'(item.end_y) & mask;
		goal[2] = int'(item.end_z) & mask;
		for (int i = 0; i < 3; i++) begin
			diff = goal[i] - pos[i];
			// zero delta still gets a negative direction; it never steps
			dir[i] = (diff > 0) ? 1 : -1;
			mag[i] = (diff < 0) ? -diff : diff;
		end
		if (mag[0] >= mag[1] && mag[0] >= mag[2])
			lead = AXIS_X;
		else if (mag[1] >= mag[2])
			lead = AXIS_Y;
		else
			lead = AXIS_Z;
		lead_i = int'(lead);
		m1 = (lead == AXIS_X) ? 1 : 0;
		m2 = (lead == AXIS_Z) ? 1 : 2;
		err1 = 2 * mag[m1] - mag[lead_i];
		err2 = 2 * mag[m2] - mag[lead_i];
		count = 0;
		forever begin
			voxel.point_x = coord_t'(pos[0]);
			voxel.point_y = coord_t'(pos[1]);
			voxel.point_z = coord_t'(pos[2]);
			voxel.last_point = (pos[lead_i] == goal[lead_i]);
			pending_voxels = {pending_voxels, voxel};
			count++;
			if (pos[lead_i] == goal[lead_i] || count >= MAX_VOXELS)
				break;
			pos[lead_i] += dir[lead_i];
			if (err1 >= 0) begin
				pos[m1] += dir[m1];
				err1 -= 2 * mag[lead_i];
			end
			if (err2 >= 0) begin
				pos[m2] += dir[m2];
				err2 -= 2 * mag[lead_i];
			end
			err1 += 2 * mag[m1];
			err2 += 2 * mag[m2];
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic lvw_in_t make_line(input int sx, input int sy, input int sz,
			input int ex, input int ey, input int ez);
		lvw_in_t item;
		item.start_x = coord_t'(sx);
		item.start_y = coord_t'(sy);
		item.start_z = coord_t'(sz);
		item.end_x = coord_t'(ex);
		item.end_y = coord_t'(ey);
		item.end_z = coord_t'(ez);
		return item;
	endfunction

	// Hold the item until the block takes it, then queue its voxels.
	// Valid stays high into the next item unless a gap is drawn.
	task automatic send_line(input lvw_in_t item);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_line(item);
		if (idle_en && $urandom_range(0, 2) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// start equals end: a single voxel flagged as last
	task automatic test_single_voxel_lines();
		send_line(make_line(0, 0, 0, 0, 0, 0));
		send_line(make_line(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX));
		send_line(make_line(21, 42, 7, 21, 42, 7));
	endtask

	// full-length lines along one axis, both directions
	task automatic test_axis_aligned_lines();
		send_line(make_line(0, 0, 0, COORD_MAX, 0, 0));
		send_line(make_line(COORD_MAX, 5, 9, 0, 5, 9));
		send_line(make_line(COORD_MAX, 0, 0, COORD_MAX, COORD_MAX, 0));
		send_line(make_line(3, COORD_MAX, 60, 3, 0, 60));
		send_line(make_line(0, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX));
		send_line(make_line(17, 33, COORD_MAX, 17, 33, 0));
	endtask

	// equal deltas: the tie picks x over y over z
	task automatic test_ties_and_diagonals();
		send_line(make_line(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
		send_line(make_line(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
		send_line(make_line(10, 10, 5, 30, 30, 9));
		send_line(make_line(5, 0, 0, 8, 20, 20));
		send_line(make_line(40, 3, 40, 20, 9, 20));
	endtask

	// minor axes with opposite signs, zero deltas and shallow slopes
	task automatic test_mixed_directions();
		send_line(make_line(0, COORD_MAX, 10, COORD_MAX, 0, 40));
		send_line(make_line(COORD_MAX, 0, COORD_MAX, 0, 40, 1));
		send_line(make_line(5, 60, 30, 50, 2, 30));
		send_line(make_line(1, 2, 3, 2, 4, 6));
		send_line(make_line(32, 32, 32, 33, 31, 32));
		send_line(make_line(0, 0, COORD_MAX, 1, COORD_MAX, 0));
	endtask

	function automatic int near_coord(input int c);
		int v;
		v = c + $urandom_range(0, 14) - 7;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return COORD_MAX;
			default: return $urandom_range(0, COORD_MAX);
		endcase
	endfunction

	// Mix of arbitrary lines, short lines anywhere and lines pinned to the
	// grid faces. With idling allowed, some chunks of ten run with none.
	task automatic test_random_lines(input int num_items, input bit allow_idle);
		lvw_in_t item;
		int      sx;
		int      sy;
		int      sz;
		for (int n = 0; n < num_items; n++) begin
			if (n % 10 == 0)
				idle_en = allow_idle && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 2))
				0: item = lvw_in_t'({$urandom, $urandom});
				1: begin
					sx = $urandom_range(0, COORD_MAX);
					sy = $urandom_range(0, COORD_MAX);
					sz = $urandom_range(0, COORD_MAX);
					item = make_line(sx, sy, sz, near_coord(sx), near_coord(sy),
						near_coord(sz));
				end
				default: item = make_line(edge_coord(), edge_coord(), edge_coord(),
					edge_coord(), edge_coord(), edge_coord());
			endcase
			send_line(item);
		end
	endtask

	// receiver stall bursts, always followed by an open cycle
	always @(posedge clk) begin
		if (!idle_en) begin
			pt_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			pt_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (pt_stall) begin
			pt_stall <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			pt_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end
	end

	// compare each voxel taken against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && pt_valid && !pt_stall) begin
			if (pending_voxels.size() == 0) begin
				report_mismatch("voxel with no line pending", int'(pt), 0);
			end else begin
				want_voxel = pending_voxels.pop_front();
				if (pt.point_x !== want_voxel.point_x)
					report_mismatch("point_x", int'(pt.point_x), int'(want_voxel.point_x));
				if (pt.point_y !== want_voxel.point_y)
					report_mismatch("point_y", int'(pt.point_y), int'(want_voxel.point_y));
				if (pt.point_z !== want_voxel.point_z)
					report_mismatch("point_z", int'(pt.point_z), int'(want_voxel.point_z));
				if (pt.last_point !== want_voxel.last_point)
					report_mismatch("last_point", int'(pt.last_point),
						int'(want_voxel.last_point));
			end
		end
	end

	// hang detection: any handshake on either channel clears the count
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (pt_valid && !pt_stall)) begin
			hang_cycles <= 0;
		end else begin
			hang_cycles <= hang_cycles + 1;
			if (hang_cycles >= HANG_LIMIT) begin
				$display("[line_voxel_walker_3d_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		pt_stall = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_voxel_lines();
		test_axis_aligned_lines();
		test_ties_and_diagonals();
		test_mixed_directions();
		test_random_lines(100, 1'b1);
		// closing stretch runs at full rate on both sides
		idle_en = 1'b0;
		test_random_lines(30, 1'b0);
		req_valid <= 1'b0;

		while (pending_voxels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[line_voxel_walker_3d_top] OK");
		else
			$display("[line_voxel_walker_3d_top] ERROR");
		$finish;
	end

endmodule
